// File: rtl/packed_word_string_utf8_check_core_assert.svh
// Assertion macros shared by the string checker RTL.
`ifndef PACKED_WORD_STRING_UTF8_CHECK_CORE_ASSERT_SVH
`define PACKED_WORD_STRING_UTF8_CHECK_CORE_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define PKWU_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, held off while reset is asserted.
`define PKWU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: rtl/pkwu_pkg.sv
// Types and constants for the packed-word UTF-8 string checker.
package pkwu_pkg;

	localparam int CAP_W = 5;
	localparam int CNT_W = 5;

	localparam logic [CAP_W-1:0] MAX_WORDS = 5'd16;
	localparam logic [CNT_W-1:0] WORDS_SAT = 5'd31;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd4;
	localparam logic [7:0]       BIAS      = 8'd128;

	typedef logic [3:0][7:0] char4_t;

	typedef enum logic [1:0] {
		VERDICT_PENDING  = 2'd0,
		VERDICT_VALID    = 2'd1,
		VERDICT_INVALID  = 2'd2,
		VERDICT_OVER_CAP = 2'd3
	} verdict_t;

	// allowed range of the next continuation byte
	typedef enum logic [2:0] {
		RNG_NORMAL = 3'd0,  // 80..BF
		RNG_A0_BF  = 3'd1,
		RNG_80_9F  = 3'd2,
		RNG_90_BF  = 3'd3,
		RNG_80_8F  = 3'd4
	} rng_t;

	typedef struct packed {
		logic [1:0] cont;
		rng_t       rng;
		logic       term;
		logic       inv;
	} chk_state_t;

	localparam chk_state_t CHK_RESET = '{cont: 2'd0, rng: RNG_NORMAL, term: 1'b0, inv: 1'b0};

	typedef struct packed {
		logic adv;   // word in stage 1 moves to the result register
		logic last;  // that word ends the string
	} step_t;

endpackage

// File: rtl/pkwu_checker.sv
// Per-string UTF-8 state, four chained byte classifiers and verdict logic.
module pkwu_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pkwu_pkg::step_t             step,
	input  pkwu_pkg::char4_t            chars,
	input  logic [pkwu_pkg::CAP_W-1:0]  capacity,
	output pkwu_pkg::verdict_t          verdict
);
	import pkwu_pkg::*;
	`include "packed_word_string_utf8_check_core_assert.svh"

	chk_state_t            state_q;
	logic [CNT_W-1:0]      words_q;
	chk_state_t            st1, st2, st3, st4;
	logic [CAP_W-1:0]      cap_eff;

	function automatic chk_state_t check_byte(chk_state_t st, logic [7:0] b);
		chk_state_t nx;
		logic [7:0] lo;
		logic [7:0] hi;
		nx = st;
		case (st.rng)
			RNG_A0_BF: begin lo = 8'hA0; hi = 8'hBF; end
			RNG_80_9F: begin lo = 8'h80; hi = 8'h9F; end
			RNG_90_BF: begin lo = 8'h90; hi = 8'hBF; end
			RNG_80_8F: begin lo = 8'h80; hi = 8'h8F; end
			default:   begin lo = 8'h80; hi = 8'hBF; end
		endcase
		if (!(st.term || st.inv)) begin
			if (b == 8'h00) begin
				nx.term = 1'b1;
				if (st.cont != 2'd0)
					nx.inv = 1'b1;
			end else if (st.cont != 2'd0) begin
				if (b >= lo && b <= hi) begin
					nx.cont = st.cont - 2'd1;
					nx.rng  = RNG_NORMAL;
				end else begin
					nx.inv = 1'b1;
				end
			end else begin
				nx.rng = RNG_NORMAL;
				if (b <= 8'h7F) begin
					nx.cont = 2'd0;
				end else if (b >= 8'hC2 && b <= 8'hDF) begin
					nx.cont = 2'd1;
				end else if (b == 8'hE0) begin
					nx.cont = 2'd2;
					nx.rng  = RNG_A0_BF;
				end else if (b == 8'hED) begin
					nx.cont = 2'd2;
					nx.rng  = RNG_80_9F;
				end else if (b >= 8'hE1 && b <= 8'hEF) begin
					nx.cont = 2'd2;
				end else if (b == 8'hF0) begin
					nx.cont = 2'd3;
					nx.rng  = RNG_90_BF;
				end else if (b >= 8'hF1 && b <= 8'hF3) begin
					nx.cont = 2'd3;
				end else if (b == 8'hF4) begin
					nx.cont = 2'd3;
					nx.rng  = RNG_80_8F;
				end else begin
					nx.inv = 1'b1;
				end
			end
		end
		return nx;
	endfunction

	always_comb begin
		st1 = check_byte(state_q, chars[0]);
		st2 = check_byte(st1, chars[1]);
		st3 = check_byte(st2, chars[2]);
		st4 = check_byte(st3, chars[3]);
	end

	assign cap_eff = (capacity > MAX_WORDS) ? MAX_WORDS : capacity;

	always_comb begin
		if (!step.last)
			verdict = VERDICT_PENDING;
		else if (words_q >= cap_eff)
			verdict = VERDICT_OVER_CAP;
		else if (st4.inv)
			verdict = VERDICT_INVALID;
		else
			verdict = VERDICT_VALID;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CHK_RESET;
			words_q <= '0;
		end else if (step.adv) begin
			if (step.last) begin
				state_q <= CHK_RESET;
				words_q <= '0;
			end else begin
				state_q <= st4;
				if (words_q != WORDS_SAT)
					words_q <= words_q + CNT_W'(1);
			end
		end
	end

	`PKWU_ASSERT_NEXT(a_hold_when_idle, clk, arst_n, !step.adv, $stable(state_q) && $stable(words_q))
	`PKWU_ASSERT_NEXT(a_clear_after_last, clk, arst_n, step.adv && step.last, (words_q == '0) && (state_q == CHK_RESET))
	`PKWU_ASSERT_IMPLIES(a_range_needs_cont, clk, arst_n, state_q.rng != RNG_NORMAL, state_q.cont != 2'd0)

endmodule

// File: rtl/packed_word_string_utf8_check_core.sv
// Top level of the packed-word UTF-8 string checker.
//
// Usage:
//   Input stream (s_axis_*): one 32-bit word per transfer, four biased
//   characters, most significant byte first; tlast marks the final word.
//   Output stream (m_axis_*): one result word per input word, carrying the
//   four decoded bytes (byte minus 128), tlast = end of string and tuser =
//   verdict (pending on every non-final word, then valid, invalid or
//   capacity exceeded on the final one). The last byte of a final word is
//   always forced to zero, so every string is terminated.
//   Config (cfg_*): capacity in words, always ready; write only while idle.
// Timing:
//   Each word passes the input register, then the result register. One word
//   per cycle sustained while m_axis_tready stays high; the four byte
//   classifiers are chained in a single combinational stage between the two registers.
// Reset: clears both stage valids, the per-string checker state and sets
//   capacity to 4 words.
// Stall: when m_axis_tready is low the result holds; the input register
//   still takes one more word if empty, then s_axis_tready drops until
//   the result drains.
module packed_word_string_utf8_check_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// input stream
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [31:0]                 s_axis_tdata,   // [31:0] packed_word
	input  logic                        s_axis_tlast,   // last_word
	// result stream
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [31:0]                 m_axis_tdata,   // [7:0] char0, [15:8] char1,
	                                                    // [23:16] char2, [31:24] char3
	output logic                        m_axis_tlast,   // end_of_string
	output logic [1:0]                  m_axis_tuser,   // [1:0] verdict
	// configuration
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pkwu_pkg::CAP_W-1:0]  cfg_data        // capacity_words
);
	import pkwu_pkg::*;
	`include "packed_word_string_utf8_check_core_assert.svh"

	// stage 1: input register
	logic               in_valid_s1;
	logic [31:0]        word_s1;
	logic               last_s1;
	// stage 2: result register
	logic               out_valid_s2;
	char4_t             data_s2;
	logic               last_s2;
	verdict_t           verdict_s2;

	logic [CAP_W-1:0]   capacity_q;
	logic               s2_ready;
	logic               in_accept;
	step_t              step;
	char4_t             chars;
	verdict_t           verdict;

	// the result register frees when empty or being taken this cycle
	assign s2_ready      = !out_valid_s2 || m_axis_tready;
	assign step.adv      = in_valid_s1 && s2_ready;
	assign step.last     = last_s1;
	assign s_axis_tready = !in_valid_s1 || s2_ready;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// unbias the four bytes; the final word always ends in a terminator
	always_comb begin
		for (int i = 0; i < 4; i++)
			chars[i] = word_s1[8*(3-i) +: 8] - BIAS;
		if (last_s1)
			chars[3] = 8'h00;
	end

	pkwu_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.chars    (chars),
		.capacity (capacity_q),
		.verdict  (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			capacity_q <= CAP_RESET;
		else if (cfg_valid && cfg_ready)
			capacity_q <= cfg_data;
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (in_accept)
				in_valid_s1 <= 1'b1;
			else if (step.adv)
				in_valid_s1 <= 1'b0;

			if (step.adv)
				out_valid_s2 <= 1'b1;
			else if (m_axis_tready)
				out_valid_s2 <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_accept) begin
			word_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (step.adv) begin
			data_s2    <= chars;
			last_s2    <= last_s1;
			verdict_s2 <= verdict;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = data_s2;
	assign m_axis_tlast  = last_s2;
	assign m_axis_tuser  = verdict_s2;

	`PKWU_ASSERT_IMPLIES(a_pending_mid_string, clk, arst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tuser == VERDICT_PENDING)
	`PKWU_ASSERT_IMPLIES(a_full_blocks_input, clk, arst_n, in_valid_s1 && m_axis_tvalid && !m_axis_tready, !s_axis_tready)

endmodule

// File: tb/packed_word_string_utf8_check_core_tb.sv
// Self-checking stream testbench for the packed-word UTF-8 string checker.
`timescale 1ns / 100ps

module packed_word_string_utf8_check_core_tb;
	import pkwu_pkg::*;

	// Two register stages between the input and result streams.
	localparam int PIPE_LATENCY = 2;
	// Watchdog limit for a run of roughly 450 words at worst-case gaps and stalls.
	localparam int CYCLE_LIMIT  = 200000;

	// One word offered on the input stream.
	typedef struct {
		logic [31:0] data;
		logic        last;
	} word_item_t;

	// One expected result word: decoded bytes, end flag and verdict.
	typedef struct {
		char4_t   chars;
		logic     last;
		verdict_t verdict;
	} string_result_t;

	typedef logic [7:0] byte_q_t[$];

	// How the result side throttles tready.
	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC
	} stall_mode_t;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [31:0]         s_axis_tdata  = '0;     // [31:0] packed_word
	logic                s_axis_tlast  = 1'b0;   // last_word
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [31:0]         m_axis_tdata;           // [7:0] char0 .. [31:24] char3
	logic                m_axis_tlast;           // end_of_string
	logic [1:0]          m_axis_tuser;           // [1:0] verdict
	logic                cfg_valid     = 1'b0;
	logic                cfg_ready;
	logic [CAP_W-1:0]    cfg_data      = '0;     // capacity_words

	packed_word_string_utf8_check_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Words waiting for the driver, and results waiting for the monitor.
	word_item_t     pending_words[$];
	string_result_t expected_results[$];

	// Shadow of the capacity register and of the per-string checker state.
	logic [CAP_W-1:0] capacity_shadow = CAP_RESET;
	logic [1:0]       cont_left       = 2'd0;
	rng_t             next_range      = RNG_NORMAL;
	logic             term_seen       = 1'b0;
	logic             utf_invalid     = 1'b0;
	logic [CNT_W-1:0] words_taken     = '0;

	// Pacing knobs, changed per phase.
	bit          steady_send = 1'b0;
	stall_mode_t stall_mode  = STALL_RANDOM;
	int          burst_left  = 0;
	int          gap_left    = 0;
	int          stall_tick  = 0;

	// Bookkeeping.
	int failures      = 0;
	int cycle_count   = 0;
	int strings_sent  = 0;
	int words_queued  = 0;
	int words_checked = 0;
	int verdict_count[4];

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// Advance the UTF-8 checker by one decoded byte. Nothing is checked once
	// the string has hit its terminator or already failed.
	function automatic void check_utf8_byte(logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		if (term_seen || utf_invalid)
			return;
		if (b == 8'h00) begin
			term_seen = 1'b1;
			// sequence cut short by the terminator
			if (cont_left != 2'd0)
				utf_invalid = 1'b1;
			return;
		end
		if (cont_left != 2'd0) begin
			case (next_range)
				RNG_A0_BF: begin lo = 8'hA0; hi = 8'hBF; end
				RNG_80_9F: begin lo = 8'h80; hi = 8'h9F; end
				RNG_90_BF: begin lo = 8'h90; hi = 8'hBF; end
				RNG_80_8F: begin lo = 8'h80; hi = 8'h8F; end
				default:   begin lo = 8'h80; hi = 8'hBF; end
			endcase
			if (b >= lo && b <= hi) begin
				cont_left--;
				next_range = RNG_NORMAL;
			end else begin
				utf_invalid = 1'b1;
			end
			return;
		end
		// lead byte; the narrowed second-byte ranges reject overlongs,
		// surrogates and code points past U+10FFFF
		next_range = RNG_NORMAL;
		if (b >= 8'hC2 && b <= 8'hDF) begin
			cont_left = 2'd1;
		end else if (b == 8'hE0) begin
			cont_left  = 2'd2;
			next_range = RNG_A0_BF;
		end else if (b == 8'hED) begin
			cont_left  = 2'd2;
			next_range = RNG_80_9F;
		end else if (b >= 8'hE1 && b <= 8'hEF) begin
			cont_left = 2'd2;
		end else if (b == 8'hF0) begin
			cont_left  = 2'd3;
			next_range = RNG_90_BF;
		end else if (b >= 8'hF1 && b <= 8'hF3) begin
			cont_left = 2'd3;
		end else if (b == 8'hF4) begin
			cont_left  = 2'd3;
			next_range = RNG_80_8F;
		end else if (b >= 8'h80) begin
			// stray continuation, C0/C1 or F5..FF
			utf_invalid = 1'b1;
		end
	endfunction

	// Expected result word for one accepted input word.
	function automatic string_result_t predict_word(logic [31:0] word, logic last);
		string_result_t   r;
		logic [CAP_W-1:0] cap;
		cap = (capacity_shadow > MAX_WORDS) ? MAX_WORDS : capacity_shadow;
		for (int i = 0; i < 4; i++)
			r.chars[i] = word[31-8*i -: 8] - BIAS;
		if (last)
			r.chars[3] = 8'h00;   // final word always terminated
		for (int i = 0; i < 4; i++)
			check_utf8_byte(r.chars[i]);
		r.last = last;
		if (last) begin
			// capacity overrides the UTF-8 result
			if (words_taken >= cap)
				r.verdict = VERDICT_OVER_CAP;
			else if (utf_invalid)
				r.verdict = VERDICT_INVALID;
			else
				r.verdict = VERDICT_VALID;
			cont_left   = 2'd0;
			next_range  = RNG_NORMAL;
			term_seen   = 1'b0;
			utf_invalid = 1'b0;
			words_taken = '0;
		end else begin
			r.verdict = VERDICT_PENDING;
			if (words_taken != WORDS_SAT)
				words_taken++;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	task automatic push_raw(input logic [31:0] data, input logic last);
		word_item_t it;
		it.data = data;
		it.last = last;
		pending_words.push_back(it);
		words_queued++;
		if (last)
			strings_sent++;
	endtask

	// Queue a string of n_words words from decoded bytes. Positions past the
	// given text get random bytes; the block forces the very last one to zero.
	task automatic push_string(input byte_q_t txt, input int n_words);
		logic [31:0] data;
		logic [7:0]  b;
		for (int w = 0; w < n_words; w++) begin
			for (int k = 0; k < 4; k++) begin
				b = (w * 4 + k < txt.size()) ? txt[w * 4 + k] : 8'($urandom_range(0, 255));
				data[31-8*k -: 8] = b + BIAS;
			end
			push_raw(data, w == n_words - 1);
		end
	endtask

	// Value in [lo, hi], leaning on the range edges.
	function automatic logic [7:0] pick_in(logic [7:0] lo, logic [7:0] hi);
		case ($urandom_range(0, 3))
			0:       return lo;
			1:       return hi;
			default: return 8'($urandom_range(int'(lo), int'(hi)));
		endcase
	endfunction

	// Append one well-formed UTF-8 character of 1..4 bytes.
	task automatic append_utf8_char(ref byte_q_t txt);
		logic [7:0] lead;
		case ($urandom_range(0, 3))
			0: txt.push_back(pick_in(8'h01, 8'h7F));
			1: begin
				txt.push_back(pick_in(8'hC2, 8'hDF));
				txt.push_back(pick_in(8'h80, 8'hBF));
			end
			2: begin
				lead = pick_in(8'hE0, 8'hEF);
				txt.push_back(lead);
				if (lead == 8'hE0)
					txt.push_back(pick_in(8'hA0, 8'hBF));
				else if (lead == 8'hED)
					txt.push_back(pick_in(8'h80, 8'h9F));
				else
					txt.push_back(pick_in(8'h80, 8'hBF));
				txt.push_back(pick_in(8'h80, 8'hBF));
			end
			default: begin
				lead = pick_in(8'hF0, 8'hF4);
				txt.push_back(lead);
				if (lead == 8'hF0)
					txt.push_back(pick_in(8'h90, 8'hBF));
				else if (lead == 8'hF4)
					txt.push_back(pick_in(8'h80, 8'h8F));
				else
					txt.push_back(pick_in(8'h80, 8'hBF));
				txt.push_back(pick_in(8'h80, 8'hBF));
				txt.push_back(pick_in(8'h80, 8'hBF));
			end
		endcase
	endtask

	// A byte likely to break a sequence.
	function automatic logic [7:0] bad_byte();
		case ($urandom_range(0, 4))
			0:       return pick_in(8'hC0, 8'hC1);
			1:       return pick_in(8'hF5, 8'hFF);
			2:       return pick_in(8'h80, 8'hBF);
			3:       return 8'h00;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Random string: mostly well-formed text with a terminator, some with
	// one corrupted byte, some pure noise. Length hugs the capacity edge.
	task automatic push_random_string(input int lim);
		byte_q_t txt;
		int      n_words;
		int      pick;
		int      body_len;
		pick = $urandom_range(0, 19);
		if (pick < 3)
			n_words = lim;
		else if (pick < 6)
			n_words = lim + 1;
		else
			n_words = $urandom_range(1, lim);
		pick = $urandom_range(0, 9);
		if (pick != 9) begin
			body_len = $urandom_range(0, n_words * 4 - 1);
			while (txt.size() < body_len)
				append_utf8_char(txt);
			if (txt.size() < n_words * 4 && $urandom_range(0, 7) != 0)
				txt.push_back(8'h00);
			if (pick >= 6 && txt.size() != 0)
				txt[$urandom_range(0, txt.size() - 1)] = bad_byte();
		end
		push_string(txt, n_words);
	endtask

	// Block is idle once nothing is queued, offered or outstanding.
	task automatic wait_idle();
		@(negedge clk);
		while (pending_words.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (PIPE_LATENCY + 2) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		capacity_shadow = value;
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------------
	// Driver: offers queued words in bursts, with random gaps between bursts
	// unless steady_send is set. The predictor runs on every accepted word.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : driver
		word_item_t nxt;
		bit         present;
		if (arst_n) begin
			present = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(predict_word(s_axis_tdata, s_axis_tlast));
				present = 1'b0;
			end
			if (!present) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_words.size() != 0) begin
					nxt = pending_words.pop_front();
					s_axis_tdata <= nxt.data;
					s_axis_tlast <= nxt.last;
					present = 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 12);
						gap_left   = steady_send ? 0 : $urandom_range(1, 5);
					end else begin
						burst_left--;
					end
				end
			end
			s_axis_tvalid <= present;
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: checks each accepted result word against the oldest
	// prediction, then picks tready for the next edge.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		string_result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$error("result word with nothing expected: data %08h", m_axis_tdata);
					failures++;
				end else begin
					want = expected_results.pop_front();
					for (int i = 0; i < 4; i++) begin
						if (m_axis_tdata[8*i +: 8] !== want.chars[i]) begin
							$error("char%0d mismatch: expected %02h, actual %02h",
								i, want.chars[i], m_axis_tdata[8*i +: 8]);
							failures++;
						end
					end
					if (m_axis_tlast !== want.last) begin
						$error("end_of_string mismatch: expected %0b, actual %0b",
							want.last, m_axis_tlast);
						failures++;
					end
					if (m_axis_tuser !== want.verdict) begin
						$error("verdict mismatch: expected %0d, actual %0d",
							want.verdict, m_axis_tuser);
						failures++;
					end
					verdict_count[want.verdict]++;
					words_checked++;
				end
			end
			stall_tick++;
			case (stall_mode)
				STALL_NONE:   m_axis_tready <= 1'b1;
				STALL_RANDOM: m_axis_tready <= ($urandom_range(0, 9) > 2);
				default:      m_axis_tready <= ((stall_tick % 11) >= 4);
			endcase
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Sequencer: reset, a directed phase, then random phases, each under
	// its own capacity and pacing.
	// ---------------------------------------------------------------------
	initial begin : sequencer
		logic [CAP_W-1:0] caps[7];
		int               lim;
		int               target;
		caps = '{5'd1, 5'd16, 5'd0, 5'd31, 5'($urandom_range(2, 15)),
			5'($urandom_range(1, 16)), 5'd4};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed strings at the reset capacity of four words.
		push_raw(32'h0000_0000, 1'b0);          // all-zero raw bits
		push_raw(32'hFFFF_FFFF, 1'b1);          // all-one raw bits
		push_raw(32'h8080_8080, 1'b1);          // empty string
		push_string('{8'h41, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
			8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00}, 3);   // 1..4 byte characters
		push_string('{8'hC0, 8'h80, 8'h00}, 1);       // overlong two-byte form
		push_string('{8'hE0, 8'h80, 8'h80}, 1);       // overlong three-byte form
		push_string('{8'hF0, 8'h8F, 8'hBF, 8'hBF, 8'h00}, 2); // overlong four-byte
		push_string('{8'hED, 8'hA0, 8'h80}, 1);       // surrogate
		push_string('{8'hED, 8'h9F, 8'hBF}, 1);       // just below surrogates
		push_string('{8'hF4, 8'h90, 8'h80, 8'h80, 8'h00}, 2); // past U+10FFFF
		push_string('{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00}, 2); // U+10FFFF itself
		push_string('{8'hF5, 8'h80, 8'h80}, 1);       // lead byte never legal
		push_string('{8'hE2, 8'h82, 8'h00}, 1);       // sequence open at terminator
		// junk after the terminator is not checked
		push_string('{8'h41, 8'h00, 8'hFF, 8'hC0, 8'h80, 8'h80, 8'h80, 8'h80}, 2);
		// too long and malformed: capacity verdict wins
		push_string('{8'hC0}, 5);

		foreach (caps[p]) begin
			wait_idle();
			write_capacity(caps[p]);
			@(negedge clk);
			steady_send = (p % 2) == 1;
			case (p % 3)
				0:       stall_mode = STALL_RANDOM;
				1:       stall_mode = STALL_NONE;
				default: stall_mode = STALL_PERIODIC;
			endcase
			lim    = (caps[p] == 0) ? 1 : ((caps[p] > MAX_WORDS) ? MAX_WORDS : caps[p]);
			target = words_queued + ((caps[p] == 0) ? 24 : 64);
			while (words_queued < target)
				push_random_string(lim);
		end

		wait_idle();
		repeat (8) @(negedge clk);
		$display("Checked %0d result words from %0d strings; capacities 0, 1, 4, 16, 31 and two random.",
			words_checked, strings_sent);
		$display("Verdicts seen: %0d valid, %0d invalid, %0d over capacity.",
			verdict_count[VERDICT_VALID], verdict_count[VERDICT_INVALID],
			verdict_count[VERDICT_OVER_CAP]);
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
